### rtl/core/jbf_pkg.sv
package jbf_pkg;

  // Geometry of the filter window and the line store
  localparam int MaxWidth   = 2048;
  localparam int Window     = 5;
  localparam int Half       = Window / 2;
  localparam int Taps       = Window * Window;
  localparam int Lines      = Window - 1;
  localparam int CenterTap  = Half * Window + Half;
  localparam int WeightBits = 16;
  localparam int PixBits    = 16;

  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = 13;
  localparam int FlushBits  = 13;
  localparam int TapBits    = $clog2(Taps);
  localparam int WordBits   = Lines * PixBits;

  // Arithmetic widths: one weight product, the weight sum and the weighted data sum
  localparam int ProdBits   = 2 * WeightBits;
  localparam int SwBits     = ProdBits + TapBits;
  localparam int SwdBits    = SwBits + 8;
  localparam int QuoBits    = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BORDER_MODE  = 2'd2;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_LOAD_RANGE,
    OP_LOAD_SPATIAL,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  guide_pixel;
    logic [7:0]  data_pixel;
    logic [7:0]  table_index;
    logic [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       frame_end;
  } out_item_t;

  // Write request towards the weight tables
  typedef struct packed {
    logic        rng_we;
    logic        sp_we;
    logic [7:0]  idx;
    logic [15:0] val;
  } wgt_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ACC,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_e;

endpackage

### rtl/core/joint_bilateral_filter_5x5_top.sv
// Streaming 5x5 joint bilateral filter.
// Input channel (in_valid_i, in_stall_o, in_item_i) carries one transaction per
// item: a pixel (guide and data value), a range or spatial weight load, or a
// flush. Output channel (out_valid_o, out_stall_i, out_item_o) returns at most
// one filtered pixel per input transaction, in raster order, lagging the input
// by two rows plus two pixels; flush transactions drain that lag at frame end.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle.
// One item is handled at a time; loads and ignored flushes end in the idle state.
// Interior pixels read the 25 taps one per cycle from the weight tables and
// accumulate them, then an 8-step serial divider forms the quotient; border
// pixels and pixels without a result skip both.
// Reset clears the counters, the window and both weight tables (the range
// table through valid bits); the line store is not cleared and needs no
// clearing pass.
// The finished result sits in an output register; while the receiver stalls,
// the next item is still taken and worked on, and the block only waits if a
// second result is ready before the first has been taken.
module joint_bilateral_filter_5x5_top
  import jbf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [12:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [11:0]          width_q;
  logic [12:0]          height_q;
  logic                 border_q;
  logic [11:0]          eff_w;
  logic [12:0]          eff_h;

  logic [ColBits-1:0]   col_q;
  logic [RowBits-1:0]   row_q;
  logic [FlushBits-1:0] flush_q;
  logic [PixBits-1:0]   win_q [Taps];
  logic [PixBits-1:0]   win_d [Taps];

  logic [ColBits-1:0]   cur_c_q;
  logic [RowBits-1:0]   cur_r_q;
  logic [PixBits-1:0]   pix_q;
  logic                 flush_op_q;

  logic [TapBits:0]     tap_q;
  logic                 p1_q, p2_q;
  logic [7:0]           d1_q, d2_q;
  logic [ProdBits-1:0]  wt_q;
  logic [SwBits-1:0]    sw_q;
  logic [SwdBits-1:0]   swd_q;
  logic [7:0]           res_q;
  logic                 fe_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  // Handshake and control strobes
  logic                 in_acc;
  logic                 is_pix_op;
  logic                 is_flush_op;
  logic                 shift_go;
  logic                 load_out;
  logic                 div_start;
  logic                 wgt_rd_en;
  logic                 div_done;
  logic [QuoBits-1:0]   div_quo;

  // Position of the incoming pixel
  logic [ColBits-1:0]   base_c, c_eff;
  logic [RowBits-1:0]   base_r, r_eff;
  logic                 wrap;

  // Shift step
  logic [WordBits-1:0]  line_rd;
  logic [WordBits-1:0]  line_wd;
  logic [PixBits-1:0]   col_px [Window];
  logic [11:0]          c1;
  logic                 c_end;
  logic [RowBits:0]     r1;
  logic                 last;
  logic                 pos_ok;
  logic [RowBits-1:0]   rc;
  logic [11:0]          cc;
  logic                 border;
  logic [ColBits-1:0]   col_next;
  logic [RowBits-1:0]   row_next;
  logic [FlushBits-1:0] flush_dec;
  logic [7:0]           cd_new;

  // Tap accumulation
  logic [TapBits-1:0]    tap_sel;
  logic [7:0]            tap_g, ctr_g;
  logic [7:0]            diff;
  logic [WeightBits-1:0] rng_w, sp_w;
  wgt_wr_t               wgt_wr;

  // Effective image size
  always_comb begin
    if (width_q < 12'd5) begin
      eff_w = 12'd5;
    end else if (width_q > 12'(MaxWidth)) begin
      eff_w = 12'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < 13'd5) ? 13'd5 : height_q;
  end

  // Accept decode and position of the next pixel or flush transaction
  always_comb begin
    in_acc      = in_valid_i && !in_stall_o;
    is_pix_op   = in_item_i.op == OP_PIXEL;
    is_flush_op = (in_item_i.op == OP_FLUSH) && (flush_q != '0);
    shift_go    = in_acc && (is_pix_op || is_flush_op);
    base_c      = (is_pix_op && flush_q != '0) ? '0 : col_q;
    base_r      = (is_pix_op && flush_q != '0) ? '0 : row_q;
    wrap        = {1'b0, base_c} >= eff_w;
    c_eff       = wrap ? '0 : base_c;
    r_eff       = wrap ? base_r + RowBits'(1) : base_r;
  end

  // Weight table writes
  always_comb begin
    wgt_wr.rng_we = in_acc && (in_item_i.op == OP_LOAD_RANGE);
    wgt_wr.sp_we  = in_acc && (in_item_i.op == OP_LOAD_SPATIAL) &&
                    (in_item_i.table_index < 8'(Taps));
    wgt_wr.idx    = in_item_i.table_index;
    wgt_wr.val    = in_item_i.table_value;
  end

  // Column shift: line store column, window and counters
  always_comb begin
    for (int k = 0; k < Lines; k++) begin
      col_px[k] = line_rd[k*PixBits +: PixBits];
    end
    col_px[Lines] = pix_q;
    for (int k = 0; k < Lines; k++) begin
      line_wd[k*PixBits +: PixBits] = col_px[k+1];
    end
    for (int k = 0; k < Window; k++) begin
      for (int j = 0; j < Window - 1; j++) begin
        win_d[k*Window + j] = win_q[k*Window + j + 1];
      end
      win_d[k*Window + Window - 1] = col_px[k];
    end
    c1    = {1'b0, cur_c_q} + 12'd1;
    c_end = c1 >= eff_w;
    r1    = {1'b0, cur_r_q} + 14'd1;
    last  = (r1 >= {1'b0, eff_h}) && c_end;
    if (cur_c_q >= ColBits'(Half)) begin
      pos_ok = cur_r_q >= RowBits'(Half);
      rc     = cur_r_q - RowBits'(Half);
      cc     = {1'b0, cur_c_q} - 12'(Half);
    end else begin
      pos_ok = cur_r_q >= RowBits'(Half + 1);
      rc     = cur_r_q - RowBits'(Half + 1);
      cc     = {1'b0, cur_c_q} + eff_w - 12'(Half);
    end
    border = (rc < RowBits'(Half)) ||
             ({1'b0, rc} + 14'(Half) >= {1'b0, eff_h}) ||
             (cc < 12'(Half)) ||
             ({1'b0, cc} + 13'(Half) >= {1'b0, eff_w});
    col_next  = c_end ? '0 : c1[ColBits-1:0];
    row_next  = c_end ? r1[RowBits-1:0] : cur_r_q;
    flush_dec = flush_q - FlushBits'(1);
    cd_new    = win_d[CenterTap][7:0];
  end

  // Tap selection and range-table address
  always_comb begin
    tap_sel = (tap_q < (TapBits+1)'(Taps)) ? tap_q[TapBits-1:0] : '0;
    tap_g   = win_q[tap_sel][15:8];
    ctr_g   = win_q[CenterTap][15:8];
    diff    = (tap_g > ctr_g) ? tap_g - ctr_g : ctr_g - tap_g;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (shift_go) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!pos_ok) begin
          state_d = flush_op_q ? ST_DONE : ST_IDLE;
        end else if (border) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (tap_q == (TapBits+1)'(Taps + 1)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = (sw_q == '0) ? ST_DONE : ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    wgt_rd_en  = (state_q == ST_ACC) && (tap_q < (TapBits+1)'(Taps));
    div_start  = (state_q == ST_DIV) && (sw_q != '0);
    load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 12'd640;
      height_q    <= 13'd480;
      border_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      flush_q     <= '0;
      tap_q       <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < Taps; t++) begin
        win_q[t] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[11:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
          CFG_BORDER_MODE:  border_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == ST_SHIFT) begin
        for (int t = 0; t < Taps; t++) begin
          win_q[t] <= win_d[t];
        end
        tap_q <= '0;
        if (flush_op_q) begin
          flush_q <= flush_dec;
          if (flush_dec == '0) begin
            col_q <= '0;
            row_q <= '0;
          end else begin
            col_q <= col_next;
            row_q <= row_next;
          end
        end else begin
          col_q   <= col_next;
          row_q   <= row_next;
          flush_q <= last ? FlushBits'({eff_w, 1'b0}) + FlushBits'(Half) : '0;
        end
      end
      if (state_q == ST_ACC) begin
        tap_q <= tap_q + (TapBits+1)'(1);
      end
      p1_q <= wgt_rd_en;
      p2_q <= p1_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (shift_go) begin
      cur_c_q    <= c_eff;
      cur_r_q    <= r_eff;
      pix_q      <= is_pix_op ? {in_item_i.guide_pixel, in_item_i.data_pixel} : '0;
      flush_op_q <= !is_pix_op;
    end
    if (state_q == ST_SHIFT) begin
      fe_q  <= flush_op_q && (flush_q == FlushBits'(1));
      sw_q  <= '0;
      swd_q <= '0;
      if (!pos_ok) begin
        res_q <= '0;
      end else begin
        res_q <= border_q ? cd_new : '0;
      end
    end
    d1_q <= win_q[tap_sel][7:0];
    d2_q <= d1_q;
    wt_q <= rng_w * sp_w;
    if (p2_q) begin
      sw_q  <= sw_q + SwBits'(wt_q);
      swd_q <= swd_q + SwdBits'({8'b0, wt_q} * d2_q);
    end
    if (state_q == ST_DIV && sw_q == '0) begin
      res_q <= win_q[CenterTap][7:0];
    end
    if (state_q == ST_WAIT && div_done) begin
      res_q <= div_quo;
    end
    if (load_out) begin
      out_item_q.out_pixel <= res_q;
      out_item_q.frame_end <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  jbf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (shift_go),
    .rd_addr_i (c_eff),
    .rd_data_o (line_rd),
    .wr_en_i   (state_q == ST_SHIFT),
    .wr_addr_i (cur_c_q),
    .wr_data_i (line_wd)
  );

  jbf_wgt_mem u_wgt_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wgt_wr),
    .rd_en_i    (wgt_rd_en),
    .rng_addr_i (diff),
    .sp_addr_i  (tap_sel),
    .rng_w_o    (rng_w),
    .sp_w_o     (sp_w)
  );

  jbf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (swd_q),
    .den_i   (sw_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_WAIT)
    else $error("divider finished outside the wait state");

  // A finished result is always placed in a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !out_valid_q |=> out_valid_q)
    else $error("result not moved to the output register");

  // The tap counter never runs past the pipeline drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> tap_q <= (TapBits+1)'(Taps + 1))
    else $error("tap counter overran");

  // A frame end transaction returns the position counters to the frame start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT && flush_op_q && flush_q == FlushBits'(1)
      |=> col_q == '0 && row_q == '0 && flush_q == '0)
    else $error("counters not cleared at frame end");
`endif

endmodule

### rtl/core/jbf_line_buf.sv
module jbf_line_buf
  import jbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [ColBits-1:0]  rd_addr_i,
  output logic [WordBits-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [ColBits-1:0]  wr_addr_i,
  input  logic [WordBits-1:0] wr_data_i
);

  // One word per column holds that column of all stored rows.
  logic [WordBits-1:0] mem_q [MaxWidth];
  logic [WordBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/jbf_wgt_mem.sv
module jbf_wgt_mem
  import jbf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wgt_wr_t               wr_i,
  input  logic                  rd_en_i,
  input  logic [7:0]            rng_addr_i,
  input  logic [TapBits-1:0]    sp_addr_i,
  output logic [WeightBits-1:0] rng_w_o,
  output logic [WeightBits-1:0] sp_w_o
);

  logic [WeightBits-1:0] rng_mem_q [256];
  logic [WeightBits-1:0] sp_mem_q [Taps];
  logic [255:0]          rng_vld_q;
  logic [WeightBits-1:0] rng_rd_q;
  logic [WeightBits-1:0] sp_rd_q;
  logic                  rng_rd_vld_q;

  // Range table storage and registered read data of both tables
  always_ff @(posedge clk_i) begin
    if (wr_i.rng_we) begin
      rng_mem_q[wr_i.idx] <= wr_i.val;
    end
    if (rd_en_i) begin
      rng_rd_q <= rng_mem_q[rng_addr_i];
      sp_rd_q  <= sp_mem_q[sp_addr_i];
    end
  end

  // The spatial taps are registers cleared at reset; range entries carry
  // valid bits so that an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < Taps; t++) begin
        sp_mem_q[t] <= '0;
      end
      rng_vld_q    <= '0;
      rng_rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.sp_we) begin
        sp_mem_q[wr_i.idx[TapBits-1:0]] <= wr_i.val;
      end
      if (wr_i.rng_we) begin
        rng_vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rng_rd_vld_q <= rng_vld_q[rng_addr_i];
      end
    end
  end

  assign rng_w_o = rng_rd_vld_q ? rng_rd_q : '0;
  assign sp_w_o  = sp_rd_q;

endmodule

### rtl/core/jbf_div.sv
module jbf_div
  import jbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SwdBits-1:0] num_i,
  input  logic [SwBits-1:0]  den_i,
  output logic               done_o,
  output logic [QuoBits-1:0] quo_o
);

  // Restoring division, one quotient bit per cycle; the quotient fits in
  // eight bits because it is a weighted mean of eight-bit values.
  logic [SwdBits-1:0] rem_q;
  logic [SwdBits-1:0] dvs_q;
  logic [QuoBits-1:0] quo_q;
  logic [2:0]         cnt_q;
  logic               busy_q;
  logic               done_q;
  logic               ge;

  assign ge = rem_q >= dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'(QuoBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dvs_q <= SwdBits'({den_i, 7'b0});
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - dvs_q : rem_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[QuoBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### verif/joint_bilateral_filter_5x5_top_test.sv
`timescale 1ns / 100ps

module joint_bilateral_filter_5x5_top_test;
  import jbf_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 100;
  localparam int HoldCycles = 600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_idx;
  logic [12:0] cfg_wdata;

  joint_bilateral_filter_5x5_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow copy of the filter state, kept in step with accepted transactions.
  logic [15:0]  pix_lines [Lines * MaxWidth];
  logic [15:0]  win_taps [Taps];
  logic [15:0]  range_wt [256];
  logic [15:0]  spatial_wt [Taps];
  int unsigned  col_pos;
  int unsigned  row_pos;
  int unsigned  drain_left;
  int unsigned  width_reg;
  int unsigned  height_reg;
  logic         border_reg;

  out_item_t    pending_pixels [$];
  int           err_cnt;
  int           sent_cnt;
  int           cycle_cnt = 0;
  bit           idle_on;
  int           hold_reqs;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("joint_bilateral_filter_5x5_top_test failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  function automatic int unsigned used_width();
    if (width_reg < Window) return Window;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    return (height_reg < Window) ? Window : height_reg;
  endfunction

  // Weighted average around the centre held in the window.
  function automatic logic [7:0] filtered_pixel(input int unsigned rc, input int unsigned cc);
    int unsigned        w;
    int unsigned        h;
    int unsigned        cg;
    int unsigned        g;
    int unsigned        diff;
    longint unsigned    wt;
    longint unsigned    sum_w;
    longint unsigned    sum_wd;
    logic [7:0]         cd;
    w = used_width();
    h = used_height();
    cg = win_taps[CenterTap][15:8];
    cd = win_taps[CenterTap][7:0];
    sum_w = 0;
    sum_wd = 0;
    if (rc < Half || rc + Half >= h || cc < Half || cc + Half >= w)
      return border_reg ? cd : 8'd0;
    for (int t = 0; t < Taps; t++) begin
      g = win_taps[t][15:8];
      diff = (g > cg) ? g - cg : cg - g;
      wt = longint'(range_wt[diff]) * longint'(spatial_wt[t]);
      sum_w += wt;
      sum_wd += wt * win_taps[t][7:0];
    end
    if (sum_w == 0) return cd;
    return 8'(sum_wd / sum_w);
  endfunction

  // Shift one pixel into the window; returns whether a centre is due.
  function automatic bit shift_pixel(input logic [15:0] pix, output int unsigned rc,
                                     output int unsigned cc, output bit last);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [15:0] column [Window];
    bit          due;
    w = used_width();
    h = used_height();
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    for (int k = 0; k < Lines; k++) column[k] = pix_lines[k * MaxWidth + c];
    column[Lines] = pix;
    for (int k = 0; k < Lines; k++) pix_lines[k * MaxWidth + c] = column[k + 1];
    for (int k = 0; k < Window; k++) begin
      for (int j = 0; j < Window - 1; j++) win_taps[k * Window + j] = win_taps[k * Window + j + 1];
      win_taps[k * Window + Window - 1] = column[k];
    end
    if (c >= Half) begin
      due = (r >= Half);
      rc = r - (due ? Half : 0);
      cc = c - Half;
    end else begin
      due = (r >= Half + 1);
      rc = r - (due ? Half + 1 : 0);
      cc = c + w - Half;
    end
    last = (r + 1 >= h) && (c + 1 >= w);
    if (c + 1 >= w) begin
      c = 0;
      r++;
    end else begin
      c++;
    end
    col_pos = c;
    row_pos = r;
    return due;
  endfunction

  // Update the shadow state for one accepted transaction and queue its result.
  task automatic predict_pixel(input in_item_t it);
    int unsigned rc;
    int unsigned cc;
    bit          last;
    bit          due;
    out_item_t   res;
    case (it.op)
      OP_LOAD_RANGE: begin
        range_wt[it.table_index] = it.table_value;
      end
      OP_LOAD_SPATIAL: begin
        if (it.table_index < Taps) spatial_wt[it.table_index] = it.table_value;
      end
      OP_FLUSH: begin
        if (drain_left != 0) begin
          due = shift_pixel(16'd0, rc, cc, last);
          drain_left--;
          res.out_pixel = due ? filtered_pixel(rc, cc) : 8'd0;
          res.frame_end = (drain_left == 0);
          if (drain_left == 0) begin
            col_pos = 0;
            row_pos = 0;
          end
          pending_pixels.push_back(res);
        end
      end
      default: begin
        if (drain_left != 0) begin
          drain_left = 0;
          col_pos = 0;
          row_pos = 0;
        end
        due = shift_pixel({it.guide_pixel, it.data_pixel}, rc, cc, last);
        if (last) drain_left = Half * used_width() + Half;
        if (due) begin
          res.out_pixel = filtered_pixel(rc, cc);
          res.frame_end = 1'b0;
          pending_pixels.push_back(res);
        end
      end
    endcase
  endtask

  // Offer one transaction, with an optional idle burst before it.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    predict_pixel(it);
    sent_cnt++;
  endtask

  task automatic send_pixel(input logic [7:0] g, input logic [7:0] d);
    in_item_t it;
    it = '{op: OP_PIXEL, guide_pixel: g, data_pixel: d, table_index: 8'($urandom),
           table_value: 16'($urandom)};
    send_item(it);
  endtask

  task automatic send_load(input op_e op, input logic [7:0] idx, input logic [15:0] val);
    in_item_t it;
    it = '{op: op, guide_pixel: 8'($urandom), data_pixel: 8'($urandom), table_index: idx,
           table_value: val};
    send_item(it);
  endtask

  task automatic send_flushes(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = '{op: OP_FLUSH, guide_pixel: 8'($urandom), data_pixel: 8'($urandom),
             table_index: 8'($urandom), table_value: 16'($urandom)};
      send_item(it);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = val[11:0];
      CFG_IMAGE_HEIGHT: height_reg = val;
      CFG_BORDER_MODE:  border_reg = val[0];
      default: ;
    endcase
  endtask

  // Random frame of pixels, then the drain; the drain may be cut short.
  task automatic send_frame(input bit cut_drain);
    int n;
    n = used_width() * used_height();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0) send_flushes(1);
      if ($urandom_range(0, 60) == 0) send_load(OP_LOAD_RANGE, 8'($urandom), 16'($urandom));
      send_pixel(8'($urandom), 8'($urandom));
    end
    if (cut_drain) send_flushes($urandom_range(0, Half * used_width()));
    else send_flushes(Half * used_width() + Half);
  endtask

  task automatic load_random_weights();
    for (int t = 0; t < Taps; t++) send_load(OP_LOAD_SPATIAL, 8'(t), 16'($urandom));
    for (int d = 0; d < 256; d += $urandom_range(1, 8))
      send_load(OP_LOAD_RANGE, 8'(d), ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom));
  endtask

  // Every result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected result pixel=%0d frame_end=%0b",
                         out_item.out_pixel, out_item.frame_end));
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.out_pixel !== want.out_pixel)
          report($sformatf("out_pixel %0d, expected %0d", out_item.out_pixel, want.out_pixel));
        if (out_item.frame_end !== want.frame_end)
          report($sformatf("frame_end %0b, expected %0b", out_item.frame_end, want.frame_end));
      end
    end
  end

  // Receiver stall: long hold-offs on request, otherwise random bursts.
  initial begin
    int burst;
    int hold_left;
    int hold_seen;
    burst = 0;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        burst--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 6) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Small frame straight after reset: tables are empty, so interior pixels
  // have zero weight sum and return their centre data.
  task automatic test_zero_weight_frame();
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_BORDER_MODE, 13'd1);
    send_flushes(2);
    send_frame(1'b0);
  endtask

  // Table loads at the extremes, ignored spatial indexes, and value corners.
  task automatic test_table_loads();
    send_load(OP_LOAD_RANGE, 8'd0, 16'hFFFF);
    send_load(OP_LOAD_RANGE, 8'd255, 16'hFFFF);
    send_load(OP_LOAD_SPATIAL, 8'd25, 16'h1234);
    send_load(OP_LOAD_SPATIAL, 8'd255, 16'hFFFF);
    for (int t = 0; t < Taps; t++) send_load(OP_LOAD_SPATIAL, 8'(t), 16'hFFFF);
    write_reg(CFG_IMAGE_WIDTH, 13'd5);
    write_reg(CFG_BORDER_MODE, 13'd0);
    for (int i = 0; i < 25; i++)
      send_pixel((i % 2 == 0) ? 8'd255 : 8'd0, (i % 3 == 0) ? 8'd255 : 8'd0);
    send_flushes(Half * used_width() + Half);
  endtask

  // Random frames of random small sizes, with noise and cut drains.
  task automatic test_random_frames(input int target);
    load_random_weights();
    while (sent_cnt < target) begin
      write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(5, 12)));
      write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(5, 8)));
      write_reg(CFG_BORDER_MODE, 13'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) load_random_weights();
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3) == 0);
      send_flushes(Half * used_width() + Half);
    end
  endtask

  // Receiver holds off while the sender keeps going, then the sender pauses.
  task automatic test_backpressure();
    write_reg(CFG_IMAGE_WIDTH, 13'd9);
    write_reg(CFG_IMAGE_HEIGHT, 13'd6);
    hold_reqs++;
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom), 8'($urandom));
    wait_drained();
    for (int i = 30; i < 54; i++) send_pixel(8'($urandom), 8'($urandom));
    send_flushes(Half * used_width() + Half);
  endtask

  // Tall frame that never ends by height, closed by shrinking the height.
  task automatic test_tall_frame();
    write_reg(CFG_IMAGE_WIDTH, 13'd6);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 60; i++) send_pixel(8'($urandom), 8'($urandom));
    write_reg(CFG_IMAGE_HEIGHT, 13'd5);
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom), 8'($urandom));
    send_flushes(Half * used_width() + Half);
  endtask

  // Over-range width clamps to the line store size; narrowing the width part
  // way through the first row moves the rest of the frame onto the next row.
  task automatic test_wide_frame();
    idle_on = 1'b0;
    write_reg(CFG_IMAGE_WIDTH, 13'hFFF);
    write_reg(CFG_IMAGE_HEIGHT, 13'd5);
    write_reg(CFG_BORDER_MODE, 13'd1);
    for (int i = 0; i < 400; i++) send_pixel(8'($urandom), 8'($urandom));
    write_reg(CFG_IMAGE_WIDTH, 13'd8);
    for (int i = 0; i < 4 * 8; i++) send_pixel(8'($urandom), 8'($urandom));
    send_flushes(Half * used_width() + Half);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    err_cnt = 0;
    sent_cnt = 0;
    hold_reqs = 0;
    idle_on = 1'b1;
    for (int i = 0; i < Lines * MaxWidth; i++) pix_lines[i] = '0;
    for (int i = 0; i < Taps; i++) begin
      win_taps[i] = '0;
      spatial_wt[i] = '0;
    end
    for (int i = 0; i < 256; i++) range_wt[i] = '0;
    col_pos = 0;
    row_pos = 0;
    drain_left = 0;
    width_reg = 640;
    height_reg = 480;
    border_reg = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_weight_frame();
    test_table_loads();
    test_backpressure();
    test_tall_frame();
    test_random_frames(1000);
    test_wide_frame();

    wait_drained();
    if (err_cnt == 0) begin
      $display("joint_bilateral_filter_5x5_top_test passed");
    end else begin
      $display("joint_bilateral_filter_5x5_top_test failed");
    end
    $finish;
  end

endmodule
